@@ sv/double_ended_stack_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Double-ended stack/queue assertion macros
// Shorthand for the concurrent checks used inside the deque modules.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_STACK_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_STACK_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DESQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define DESQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed: next-cycle implication");

`endif

@@ sv/desq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended stack/queue package
// Transfer types, operation and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package desq_pkg;

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP        = 3'd2,
      MODE_PEEK       = 3'd3,
      MODE_DUMP       = 3'd4
   } desq_mode_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_POP_EMPTY  = 2'd1,
      STAT_PEEK_EMPTY = 2'd2,
      STAT_FULL       = 2'd3
   } desq_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PEEK,
      S_DUMP
   } desq_state_type;

   typedef struct packed {
      logic [2:0]          mode;
      logic signed [31:0]  value;
   } desq_req_type;

   typedef struct packed {
      logic signed [31:0]  data;
      logic [1:0]          status;
      logic                last;
   } desq_rsp_type;

   typedef struct packed {
      logic            wr_front;
      logic            wr_back;
      logic            pop;
      logic            rd_first;
      logic            rd_next;
      logic            emit_data;
      logic            emit_last;
      logic            emit_err;
      desq_status_type err_code;
   } desq_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic dump_last;
   } desq_sts_type;

endpackage

@@ sv/desq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Deque controller
// Decodes each accepted request and sequences peek and dump reads.
// ----------------------------------------------------------------------------
module desq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            mode,
   input  desq_pkg::desq_sts_type sts,
   output logic                  busy,
   output desq_pkg::desq_cmd_type cmd
);

   desq_pkg::desq_state_type state_ff;
   desq_pkg::desq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= desq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.err_code = desq_pkg::STAT_OK;
      state_in = state_ff;
      busy     = (state_ff != desq_pkg::S_IDLE);
      unique case (state_ff)
         desq_pkg::S_IDLE: begin
            if (start) begin
               unique case (mode)
                  desq_pkg::MODE_PUSH_FRONT: begin
                     if (sts.full) begin
                        cmd.emit_err = 1'b1;
                        cmd.err_code = desq_pkg::STAT_FULL;
                     end else begin
                        cmd.wr_front = 1'b1;
                     end
                  end
                  desq_pkg::MODE_PUSH_BACK: begin
                     if (sts.full) begin
                        cmd.emit_err = 1'b1;
                        cmd.err_code = desq_pkg::STAT_FULL;
                     end else begin
                        cmd.wr_back = 1'b1;
                     end
                  end
                  desq_pkg::MODE_POP: begin
                     if (sts.empty) begin
                        cmd.emit_err = 1'b1;
                        cmd.err_code = desq_pkg::STAT_POP_EMPTY;
                     end else begin
                        cmd.pop = 1'b1;
                     end
                  end
                  desq_pkg::MODE_PEEK: begin
                     if (sts.empty) begin
                        cmd.emit_err = 1'b1;
                        cmd.err_code = desq_pkg::STAT_PEEK_EMPTY;
                     end else begin
                        cmd.rd_first = 1'b1;
                        state_in     = desq_pkg::S_PEEK;
                     end
                  end
                  desq_pkg::MODE_DUMP: begin
                     // An empty store dumps nothing.
                     if (!sts.empty) begin
                        cmd.rd_first = 1'b1;
                        state_in     = desq_pkg::S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         desq_pkg::S_PEEK: begin
            cmd.emit_data = 1'b1;
            cmd.emit_last = 1'b1;
            state_in      = desq_pkg::S_IDLE;
         end
         desq_pkg::S_DUMP: begin
            cmd.emit_data = 1'b1;
            cmd.emit_last = sts.dump_last;
            if (sts.dump_last) begin
               state_in = desq_pkg::S_IDLE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         default: begin
            state_in = desq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

@@ sv/desq_dp.sv @@
// ----------------------------------------------------------------------------
// Deque datapath
// Ring storage with front pointer and occupancy count, read register,
// dump offset counter and the registered result stage.
// ----------------------------------------------------------------------------
`include "double_ended_stack_queue_defines.svh"

module desq_dp #(
   parameter int DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic signed [31:0]     value,
   input  desq_pkg::desq_cmd_type cmd,
   output desq_pkg::desq_sts_type sts,
   output logic                   rsp_strobe,
   output desq_pkg::desq_rsp_type rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic signed [31:0]     mem_ff [DEPTH];
   logic signed [31:0]     rd_data_ff;
   logic [AW-1:0]          front_ff;
   logic [AW-1:0]          front_in;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [AW-1:0]          idx_ff;
   logic [AW-1:0]          idx_in;
   logic                   rsp_strobe_ff;
   desq_pkg::desq_rsp_type rsp_ff;
   desq_pkg::desq_rsp_type rsp_in;
   logic [AW-1:0]          front_dec;
   logic [AW-1:0]          front_inc;
   logic [AW-1:0]          idx_next;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [CW-1:0]          idx_count;

   // Ring addition: both operands are below DEPTH, so one subtract wraps it.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_X) begin
         s = s - DEPTH_X;
      end
      return s[AW-1:0];
   endfunction

   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + 1'b1;
   assign idx_next  = idx_ff + 1'b1;
   assign idx_count = CW'(idx_ff) + CW'(1);

   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == DEPTH_C);
   assign sts.dump_last = (idx_count == count_ff);

   // Push at the back lands count slots past the front; count is below DEPTH here.
   assign wr_addr = cmd.wr_front ? front_dec : wrap_add(front_ff, count_ff[AW-1:0]);
   assign rd_addr = cmd.rd_first ? front_ff : wrap_add(front_ff, idx_next);

   always_ff @(posedge clock) begin
      if (cmd.wr_front || cmd.wr_back) begin
         mem_ff[wr_addr] <= value;
      end
      if (cmd.rd_first || cmd.rd_next) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.wr_front) begin
         front_in = front_dec;
         count_in = count_ff + 1'b1;
      end else if (cmd.wr_back) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         front_in = front_inc;
         count_in = count_ff - 1'b1;
      end
      if (cmd.rd_first) begin
         idx_in = '0;
      end else if (cmd.rd_next) begin
         idx_in = idx_next;
      end
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = desq_pkg::STAT_OK;
      if (cmd.emit_err) begin
         rsp_in.status = cmd.err_code;
         rsp_in.last   = 1'b1;
      end else if (cmd.emit_data) begin
         rsp_in.data = rd_data_ff;
         rsp_in.last = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         front_ff      <= front_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= cmd.emit_err || cmd.emit_data;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   `DESQ_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `DESQ_ASSERT_NEXT(a_push_grows, clock, reset, cmd.wr_front || cmd.wr_back, count_ff == $past(count_ff) + 1'b1)
   `DESQ_ASSERT_SAME(a_read_nonempty, clock, reset, cmd.emit_data || cmd.rd_first || cmd.rd_next, !sts.empty)
   `DESQ_ASSERT_NEXT(a_last_strobed, clock, reset, cmd.emit_data && cmd.emit_last, rsp_strobe_ff && rsp_ff.last)

endmodule

@@ sv/double_ended_stack_queue.sv @@
// Push, pop, unknown modes and error results leave the controller idle; a new request is taken next cycle.
// Error results appear on the response port in the cycle after the request transfer.
// Peek: the read passes the read register and the result stage; busy holds off a new request in the peek state.
// Dump of N entries: one entry per cycle from the single read port; busy stays high until the last is read.
// Synchronous active-high reset empties the store (front and count cleared); contents are not cleared.
// Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// Double-ended stack/queue
// Bounded ring of signed 32-bit values with push/pop at the front, append at
// the back, peek, and a full front-to-back dump.
// ----------------------------------------------------------------------------
module double_ended_stack_queue #(
   parameter int DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  desq_pkg::desq_req_type req_payload,
   output logic                   rsp_strobe,
   output desq_pkg::desq_rsp_type rsp_payload
);

   desq_pkg::desq_cmd_type cmd;
   desq_pkg::desq_sts_type sts;

   desq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mode  (req_payload.mode),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   desq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .value       (req_payload.value),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended stack/queue testbench
// Drives push, pop, peek, dump and unused commands through the start/busy
// port and checks every strobed result against an in-bench model of the ring.
// ----------------------------------------------------------------------------
module tb;

   localparam int STORE_DEPTH  = 32;
   localparam int RANDOM_ITEMS = 500;
   localparam int PHASE_ITEMS  = 40;
   localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 8;
   // The slowest run is about 600 items, each as long as a full dump, plus idle gaps between bursts.
   localparam int CYCLE_LIMIT  = 400000;

   class deque_scoreboard #(int DEPTH = 32);
      logic signed [31:0]     ring [DEPTH];
      int unsigned            head;
      int unsigned            fill;
      desq_pkg::desq_rsp_type expected_results [$];
      int                     errors;

      function new();
         head = 0;
         fill = 0;
         errors = 0;
      endfunction

      function void report_mismatch(string what);
         $display("mismatch: %s", what);
         errors++;
      endfunction

      function void add_result(logic signed [31:0] data,
                               desq_pkg::desq_status_type status, logic last);
         desq_pkg::desq_rsp_type r;
         r.data   = data;
         r.status = status;
         r.last   = last;
         expected_results.push_back(r);
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Updates the ring for one accepted transfer and queues its results.
      function void note_request(desq_pkg::desq_req_type item);
         case (item.mode)
            desq_pkg::MODE_PUSH_FRONT: begin
               if (fill >= DEPTH) begin
                  add_result('0, desq_pkg::STAT_FULL, 1'b1);
               end else begin
                  head = (head + DEPTH - 1) % DEPTH;
                  ring[head] = item.value;
                  fill++;
               end
            end
            desq_pkg::MODE_PUSH_BACK: begin
               if (fill >= DEPTH) begin
                  add_result('0, desq_pkg::STAT_FULL, 1'b1);
               end else begin
                  ring[(head + fill) % DEPTH] = item.value;
                  fill++;
               end
            end
            desq_pkg::MODE_POP: begin
               if (fill == 0) begin
                  add_result('0, desq_pkg::STAT_POP_EMPTY, 1'b1);
               end else begin
                  head = (head + 1) % DEPTH;
                  fill--;
               end
            end
            desq_pkg::MODE_PEEK: begin
               if (fill == 0) add_result('0, desq_pkg::STAT_PEEK_EMPTY, 1'b1);
               else add_result(ring[head], desq_pkg::STAT_OK, 1'b1);
            end
            desq_pkg::MODE_DUMP: begin
               for (int i = 0; i < fill; i++)
                  add_result(ring[(head + i) % DEPTH], desq_pkg::STAT_OK, (i + 1 == fill));
            end
            default: ;
         endcase
      endfunction

      function void check_response(desq_pkg::desq_rsp_type got);
         desq_pkg::desq_rsp_type exp;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with none expected: data %0d status %0d last %0d",
                                      got.data, got.status, got.last));
            return;
         end
         exp = expected_results.pop_front();
         if (got.data !== exp.data)
            report_mismatch($sformatf("data got %0d expected %0d", got.data, exp.data));
         if (got.status !== exp.status)
            report_mismatch($sformatf("status got %0d expected %0d", got.status, exp.status));
         if (got.last !== exp.last)
            report_mismatch($sformatf("last got %0d expected %0d", got.last, exp.last));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   desq_pkg::desq_req_type req_payload;
   logic                   rsp_strobe;
   desq_pkg::desq_rsp_type rsp_payload;

   deque_scoreboard #(STORE_DEPTH) sb;
   int unsigned cycle_count;

   double_ended_stack_queue #(.DEPTH(STORE_DEPTH)) uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      cycle_count = 0;
      sb = new();
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_payload);
   end

   function automatic desq_pkg::desq_req_type make_item(logic [2:0] mode,
                                                        logic signed [31:0] value);
      desq_pkg::desq_req_type item;
      item.mode  = mode;
      item.value = value;
      return item;
   endfunction

   // Start stays high after the transfer so that a following item can go back to back.
   task automatic send_item(input desq_pkg::desq_req_type item);
      start <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom();
      endcase
   endfunction

   // Phase bias: 0 favors pushes toward a full ring, 1 favors pops, 2 is mixed.
   function automatic logic [2:0] random_mode(int bias);
      int roll;
      int w_front, w_back, w_pop, w_peek, w_dump;
      roll = $urandom_range(0, 99);
      case (bias)
         0: begin w_front = 40; w_back = 40; w_pop = 5;  w_peek = 7;  w_dump = 5; end
         1: begin w_front = 10; w_back = 10; w_pop = 55; w_peek = 12; w_dump = 8; end
         default: begin w_front = 20; w_back = 20; w_pop = 25; w_peek = 20; w_dump = 12; end
      endcase
      if (roll < w_front) return desq_pkg::MODE_PUSH_FRONT;
      roll -= w_front;
      if (roll < w_back) return desq_pkg::MODE_PUSH_BACK;
      roll -= w_back;
      if (roll < w_pop) return desq_pkg::MODE_POP;
      roll -= w_pop;
      if (roll < w_peek) return desq_pkg::MODE_PEEK;
      roll -= w_peek;
      if (roll < w_dump) return desq_pkg::MODE_DUMP;
      return 3'($urandom_range(5, 7));
   endfunction

   initial begin
      desq_pkg::desq_req_type directed [$];
      desq_pkg::desq_req_type item;
      int counted;
      int bias;
      int burst_left;
      bit use_gaps;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty-store errors, an empty dump and the unused codes come first.
      directed.push_back(make_item(desq_pkg::MODE_PEEK, 32'sd5));
      directed.push_back(make_item(desq_pkg::MODE_POP, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_DUMP, 32'sd0));
      directed.push_back(make_item(3'd5, 32'sh7fffffff));
      directed.push_back(make_item(3'd6, -32'sd1));
      directed.push_back(make_item(3'd7, 32'sh80000000));
      directed.push_back(make_item(desq_pkg::MODE_PUSH_FRONT, 32'sh7fffffff));
      directed.push_back(make_item(desq_pkg::MODE_PUSH_BACK, 32'sh80000000));
      directed.push_back(make_item(desq_pkg::MODE_PUSH_FRONT, -32'sd1));
      directed.push_back(make_item(desq_pkg::MODE_PUSH_BACK, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_PEEK, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_DUMP, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_POP, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_PEEK, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_PUSH_BACK, 32'sh55555555));
      directed.push_back(make_item(desq_pkg::MODE_DUMP, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_POP, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_POP, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_POP, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_POP, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_POP, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_PEEK, 32'sd0));
      directed.push_back(make_item(desq_pkg::MODE_DUMP, 32'sd0));
      foreach (directed[i]) send_item(directed[i]);
      wait_until_drained();

      // Random phases; each ends with the sender holding off until all results are in.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         bias = $urandom_range(0, 2);
         use_gaps = ($urandom_range(0, 3) != 0);
         burst_left = $urandom_range(1, 12);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            item = make_item(random_mode(bias), random_value());
            send_item(item);
            if (item.mode <= desq_pkg::MODE_DUMP) counted++;
            burst_left--;
            if (use_gaps && burst_left == 0) begin
               idle_cycles($urandom_range(1, 6));
               burst_left = $urandom_range(1, 12);
            end
         end
         wait_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
